// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file prfu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define PRFU_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("prfu assertion failed");

// Checked on every rising edge, reset included.
`define PRFU_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("prfu assertion failed");

`endif

// ===== rtl/core/prfu_pkg.sv =====
`default_nettype none

package prfu_pkg;

  localparam int MAX_FIELDS   = 8;
  localparam int MAX_WIDTH    = 31;
  localparam int BYTE_BITS    = 8;
  localparam int MAX_RESULTS  = 8;

  localparam int FIELD_W      = 3;
  localparam int WIDTH_W      = 5;
  localparam int BIAS_W       = 8;
  localparam int BUF_W        = 39;
  localparam int HELD_W       = 6;
  localparam int INDEX_W      = 33;
  localparam int COUNT_W      = 4;
  localparam int RECORD_W     = 32;
  localparam int WIDTHS_W     = 40;
  localparam int BIASES_W     = 64;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 64;
  localparam int RESULT_CNT_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_COUNT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_WIDTHS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FIELD_BIASES = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RECORD_COUNT = 3'd3;

  typedef struct packed {
    logic load_byte;
    logic commit;
    logic miss;
    logic move;
    logic move_last;
  } prfu_cmd_t;

  typedef struct packed {
    logic run_ok;
    logic hit;
    logic table_end;
  } prfu_status_t;

  typedef struct packed {
    logic               found;
    logic [FIELD_W-1:0] idx;
  } prfu_pick_t;

  function automatic prfu_pick_t lowest_set(input logic [MAX_FIELDS-1:0] m);
    prfu_pick_t p;
    p = '0;
    for (int i = MAX_FIELDS - 1; i >= 0; i--) begin
      if (m[i]) begin
        p.found = 1'b1;
        p.idx   = FIELD_W'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/prfu_datapath.sv =====
`default_nettype none

module prfu_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [prfu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [prfu_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [prfu_pkg::BYTE_BITS-1:0]      in_byte,
  input  prfu_pkg::prfu_cmd_t                 cmd,
  output prfu_pkg::prfu_status_t              status,
  output logic [prfu_pkg::FIELD_W-1:0]        field_number,
  output logic signed [prfu_pkg::INDEX_W-1:0] symbol_index,
  output logic                                record_end,
  output logic                                table_end,
  output logic                                last
);
  import prfu_pkg::*;

  logic [COUNT_W-1:0]  field_count;
  logic [WIDTHS_W-1:0] field_widths;
  logic [BIASES_W-1:0] field_biases;
  logic [RECORD_W-1:0] record_count;

  logic [BUF_W-1:0]    bit_buffer;
  logic [HELD_W-1:0]   bits_held;
  logic [FIELD_W-1:0]  current_field;
  logic [RECORD_W-1:0] records_done;

  logic [FIELD_W-1:0]        stg_field;
  logic signed [INDEX_W-1:0] stg_index;
  logic                      stg_record_end;
  logic                      stg_table_end;

  logic [COUNT_W-1:0]    cnt_eff;
  logic [WIDTH_W-1:0]    fw_raw [MAX_FIELDS];
  logic [WIDTH_W-1:0]    fw [MAX_FIELDS];
  logic [MAX_FIELDS-1:0] act;
  logic [MAX_FIELDS-1:0] from_cur;
  logic [MAX_FIELDS-1:0] after_f;
  prfu_pick_t            pick_cur;
  prfu_pick_t            pick_first;
  prfu_pick_t            pick_next;
  logic [FIELD_W-1:0]    f;
  logic [WIDTH_W-1:0]    w;
  logic [BIAS_W-1:0]     bias;
  logic [MAX_WIDTH-1:0]  bits;
  logic signed [INDEX_W-1:0] idx;
  logic                  rec_end;
  logic                  rec_match;
  logic [BUF_W-1:0]      shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count  <= COUNT_W'(1);
      field_widths <= '0;
      field_biases <= '0;
      record_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIELD_COUNT:  field_count  <= cfg_data[COUNT_W-1:0];
        REG_FIELD_WIDTHS: field_widths <= cfg_data[WIDTHS_W-1:0];
        REG_FIELD_BIASES: field_biases <= cfg_data[BIASES_W-1:0];
        REG_RECORD_COUNT: record_count <= cfg_data[RECORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (field_count == '0) begin
      cnt_eff = COUNT_W'(1);
    end else if (field_count > COUNT_W'(MAX_FIELDS)) begin
      cnt_eff = COUNT_W'(MAX_FIELDS);
    end else begin
      cnt_eff = field_count;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_FIELDS; i++) begin
      fw_raw[i] = field_widths[i*WIDTH_W +: WIDTH_W];
      fw[i]     = (fw_raw[i] > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : fw_raw[i];
      act[i]    = (COUNT_W'(i) < cnt_eff) && (fw[i] != '0);
      from_cur[i] = act[i] && (FIELD_W'(i) >= current_field);
    end
  end

  assign pick_cur   = lowest_set(from_cur);
  assign pick_first = lowest_set(act);
  assign f          = pick_cur.found ? pick_cur.idx : pick_first.idx;
  assign w          = fw[f];

  always_comb begin
    for (int i = 0; i < MAX_FIELDS; i++) begin
      after_f[i] = act[i] && (FIELD_W'(i) > f);
    end
  end

  assign pick_next = lowest_set(after_f);
  assign rec_end   = !pick_next.found;
  assign bias      = field_biases[f*BIAS_W +: BIAS_W];
  assign bits      = bit_buffer[MAX_WIDTH-1:0] & ~({MAX_WIDTH{1'b1}} << w);
  assign idx       = INDEX_W'(bits) + {{(INDEX_W-BIAS_W){bias[BIAS_W-1]}}, bias};
  assign rec_match = ({1'b0, records_done} + (RECORD_W+1)'(1)) == {1'b0, record_count};
  assign shifted   = BUF_W'(in_byte) << bits_held;

  assign status.run_ok    = pick_first.found && (records_done < record_count);
  assign status.hit       = HELD_W'(w) <= bits_held;
  assign status.table_end = rec_end && rec_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer    <= '0;
      bits_held     <= '0;
      current_field <= '0;
      records_done  <= '0;
    end else if (cmd.load_byte) begin
      if (bits_held <= HELD_W'(BUF_W - BYTE_BITS)) begin
        bit_buffer <= bit_buffer | shifted;
        bits_held  <= bits_held + HELD_W'(BYTE_BITS);
      end
    end else if (cmd.commit) begin
      bit_buffer    <= bit_buffer >> w;
      bits_held     <= bits_held - HELD_W'(w);
      records_done  <= records_done + RECORD_W'(rec_end);
      current_field <= rec_end ? '0 : pick_next.idx;
    end else if (cmd.miss) begin
      current_field <= f;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      stg_field      <= f;
      stg_index      <= idx;
      stg_record_end <= rec_end;
      stg_table_end  <= status.table_end;
    end
    if (cmd.move) begin
      field_number <= stg_field;
      symbol_index <= stg_index;
      record_end   <= stg_record_end;
      table_end    <= stg_table_end;
      last         <= cmd.move_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/prfu_ctrl.sv =====
`default_nettype none

module prfu_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  prfu_pkg::prfu_status_t status,
  output prfu_pkg::prfu_cmd_t    cmd
);
  import prfu_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STEP  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic                    stg_valid;
  logic                    stg_valid_next;
  logic [RESULT_CNT_W-1:0] n;
  logic [RESULT_CNT_W-1:0] n_next;
  logic                    out_valid_next;
  logic                    out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    stg_valid_next = stg_valid;
    n_next         = n;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid && status.run_ok) begin
          cmd.load_byte = 1'b1;
          n_next        = '0;
          state_next    = ST_STEP;
        end
      end
      ST_STEP: begin
        if (out_free) begin
          if (status.hit) begin
            cmd.commit     = 1'b1;
            cmd.move       = stg_valid;
            stg_valid_next = 1'b1;
            n_next         = n + RESULT_CNT_W'(1);
            if (status.table_end || n == RESULT_CNT_W'(MAX_RESULTS - 1)) begin
              state_next = ST_FLUSH;
            end
          end else begin
            cmd.miss       = 1'b1;
            cmd.move       = stg_valid;
            cmd.move_last  = 1'b1;
            stg_valid_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          cmd.move       = 1'b1;
          cmd.move_last  = 1'b1;
          stg_valid_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = cmd.move ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stg_valid <= 1'b0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      stg_valid <= stg_valid_next;
      n         <= n_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/packed_record_field_unpacker.sv =====
// A byte's beat loads the bit buffer; each field it releases passes through a staging register
// to the output register. Extraction takes one step per cycle in the shared shift-and-add unit
// while the output is not stalled; no new byte is taken until the current one is done.
// Reset clears the bit buffer, the field and record counters and the registers
// (field count to 1, all others to 0); no output beat is pending after reset.
`default_nettype none

module packed_record_field_unpacker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [prfu_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [prfu_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [prfu_pkg::BYTE_BITS-1:0]      in_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [prfu_pkg::FIELD_W-1:0]        field_number,
  output logic signed [prfu_pkg::INDEX_W-1:0] symbol_index,
  output logic                                record_end,
  output logic                                table_end,
  output logic                                last
);
  import prfu_pkg::*;

  prfu_cmd_t    cmd;
  prfu_status_t status;

  assign cfg_ready = 1'b1;

  prfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  prfu_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_byte      (in_byte),
    .cmd          (cmd),
    .status       (status),
    .field_number (field_number),
    .symbol_index (symbol_index),
    .record_end   (record_end),
    .table_end    (table_end),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== rtl/core/prfu_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module prfu_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [prfu_pkg::INDEX_W-1:0]     symbol_index,
  input logic                             record_end,
  input logic                             table_end,
  input logic                             last
);

  `PRFU_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(symbol_index) && $stable(last))
  `PRFU_ASSERT(a_table_end_closes, clk, rst, out_valid && table_end |-> record_end && last)
  `PRFU_ASSERT(a_busy_mid_byte, clk, rst, out_valid && !last |-> !in_ready)
  `PRFU_ASSERT_ALWAYS(a_reset_state, clk, rst |=> !out_valid && in_ready)

endmodule

bind packed_record_field_unpacker prfu_checker u_prfu_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .symbol_index (symbol_index),
  .record_end   (record_end),
  .table_end    (table_end),
  .last         (last)
);

`default_nettype wire

// ===== bench/tb_packed_record_field_unpacker.sv =====
`timescale 1ns / 1ps

module tb_packed_record_field_unpacker;
  import prfu_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0]        fnum;
    logic signed [INDEX_W-1:0] sym;
    logic                      rend;
    logic                      tend;
    logic                      lst;
  } field_result_t;

  typedef enum int {BY_MODEL, NO_RESULT, ONE_RESULT} row_check_t;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  value;
    bit                     from_done;
    logic [BYTE_BITS-1:0]   data;
    row_check_t             check;
    field_result_t          want;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [BYTE_BITS-1:0]      in_byte = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [FIELD_W-1:0]        field_number;
  logic signed [INDEX_W-1:0] symbol_index;
  logic                      record_end;
  logic                      table_end;
  logic                      last;

  logic [COUNT_W-1:0]  cnt_reg = COUNT_W'(1);
  logic [WIDTHS_W-1:0] widths_reg = '0;
  logic [BIASES_W-1:0] biases_reg = '0;
  logic [RECORD_W-1:0] recs_reg = '0;
  logic [BUF_W-1:0]    bit_store = '0;
  int                  bits_in = 0;
  int                  cur_field = 0;
  logic [RECORD_W-1:0] recs_done = '0;

  field_result_t pending_fields[$];
  plan_row_t     plan[$];
  field_result_t seen;
  int            mismatches = 0;
  int            live_bytes = 0;
  bit            calm = 1'b0;

  packed_record_field_unpacker i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .field_number (field_number),
    .symbol_index (symbol_index),
    .record_end   (record_end),
    .table_end    (table_end),
    .last         (last)
  );

  always #6 clk = ~clk;

  function automatic int live_count();
    int c;
    c = int'(cnt_reg);
    if (c == 0) c = 1;
    if (c > MAX_FIELDS) c = MAX_FIELDS;
    return c;
  endfunction

  function automatic int field_width(input int f);
    int w;
    w = int'(widths_reg[f*WIDTH_W +: WIDTH_W]);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int next_live(input int from, input int cnt);
    int f;
    f = from;
    while (f < cnt && field_width(f) == 0) f++;
    return f;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FIELD_COUNT: begin
        cnt_reg = val[COUNT_W-1:0];
      end
      REG_FIELD_WIDTHS: begin
        widths_reg = val[WIDTHS_W-1:0];
      end
      REG_FIELD_BIASES: begin
        biases_reg = val[BIASES_W-1:0];
      end
      REG_RECORD_COUNT: begin
        recs_reg = val[RECORD_W-1:0];
      end
      default: begin
      end
    endcase
  endfunction

  // Returns -1 for an ignored byte, else the number of fields it releases.
  function automatic int unpack_byte(input logic [BYTE_BITS-1:0] b, input bit keep);
    int            cnt;
    int            first;
    int            f;
    int            g;
    int            w;
    int            n;
    bit            have;
    logic [BUF_W-1:0] got;
    longint        sum;
    field_result_t r;
    field_result_t prev;
    n = 0;
    have = 1'b0;
    prev = '0;
    cnt = live_count();
    first = next_live(0, cnt);
    if (first >= cnt || recs_done >= recs_reg) return -1;
    if (bits_in + BYTE_BITS <= BUF_W) begin
      bit_store = bit_store | (BUF_W'(b) << bits_in);
      bits_in += BYTE_BITS;
    end
    while (n < MAX_RESULTS) begin
      f = next_live(cur_field, cnt);
      if (f >= cnt) f = first;
      cur_field = f;
      w = field_width(f);
      if (w > bits_in) break;
      got = bit_store & ((BUF_W'(1) << w) - BUF_W'(1));
      bit_store = bit_store >> w;
      bits_in -= w;
      sum = longint'(got) + longint'($signed(biases_reg[f*BIAS_W +: BIAS_W]));
      g = next_live(f + 1, cnt);
      r.fnum = FIELD_W'(f);
      r.sym = INDEX_W'(sum);
      r.rend = (g >= cnt);
      r.tend = 1'b0;
      r.lst = 1'b0;
      if (r.rend) begin
        recs_done = recs_done + 1'b1;
        cur_field = 0;
        r.tend = (recs_done == recs_reg);
      end else begin
        cur_field = g;
      end
      if (have && keep) pending_fields = {pending_fields, prev};
      prev = r;
      have = 1'b1;
      n++;
      if (r.tend) break;
    end
    if (have && keep) begin
      prev.lst = 1'b1;
      pending_fields = {pending_fields, prev};
    end
    return n;
  endfunction

  function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val, input bit rel);
    plan_row_t row;
    row = '{check: BY_MODEL, default: '0};
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.value = val;
    row.from_done = rel;
    row.check = BY_MODEL;
    plan = {plan, row};
  endfunction

  function automatic void add_byte(input logic [BYTE_BITS-1:0] b, input row_check_t chk,
                                   input int f = 0, input longint sym = 0,
                                   input bit rend = 1'b0, input bit tend = 1'b0);
    plan_row_t row;
    row = '{check: BY_MODEL, default: '0};
    row.data = b;
    row.check = chk;
    row.want.fnum = FIELD_W'(f);
    row.want.sym = INDEX_W'(sym);
    row.want.rend = rend;
    row.want.tend = tend;
    row.want.lst = 1'b1;
    plan = {plan, row};
  endfunction

  function automatic logic [WIDTHS_W-1:0] pick_widths();
    logic [WIDTHS_W-1:0] v;
    int                  roll;
    v = '0;
    if ($urandom_range(0, 9) == 0) return WIDTHS_W'({$urandom, $urandom});
    for (int i = 0; i < MAX_FIELDS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) v[i*WIDTH_W +: WIDTH_W] = '0;
      else if (roll < 22) v[i*WIDTH_W +: WIDTH_W] = WIDTH_W'($urandom_range(20, MAX_WIDTH));
      else v[i*WIDTH_W +: WIDTH_W] = WIDTH_W'($urandom_range(1, 12));
    end
    return v;
  endfunction

  function automatic logic [RECORD_W-1:0] pick_records();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return '0;
    if (roll < 10) return recs_done;
    if (roll < 13) return RECORD_W'($urandom);
    return recs_done + RECORD_W'($urandom_range(1, 12));
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic send_byte(input logic [BYTE_BITS-1:0] b, input bit keep, output int n);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = unpack_byte(b, keep);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 19);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_fields.size() == 0) begin
        $error("unexpected beat: field_number %0d symbol_index %0d", field_number,
               symbol_index);
        mismatches++;
      end else begin
        seen = pending_fields.pop_front();
        if (field_number !== seen.fnum) begin
          $error("field_number: expected %0d, actual %0d", seen.fnum, field_number);
          mismatches++;
        end
        if (symbol_index !== seen.sym) begin
          $error("symbol_index: expected %0d, actual %0d", seen.sym, symbol_index);
          mismatches++;
        end
        if (record_end !== seen.rend) begin
          $error("record_end: expected %0d, actual %0d", seen.rend, record_end);
          mismatches++;
        end
        if (table_end !== seen.tend) begin
          $error("table_end: expected %0d, actual %0d", seen.tend, table_end);
          mismatches++;
        end
        if (last !== seen.lst) begin
          $error("last: expected %0d, actual %0d", seen.lst, last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int                    n;
    int                    nb;
    int                    roll;
    bit                    first_phase;
    logic [CFG_DATA_W-1:0] v;
    logic [BYTE_BITS-1:0]  b;
    first_phase = 1'b1;

    add_byte(8'hA5, NO_RESULT);
    add_cfg(REG_FIELD_COUNT, 64'd1, 1'b0);
    add_cfg(REG_FIELD_WIDTHS, 64'd8, 1'b0);
    add_cfg(REG_FIELD_BIASES, 64'h80, 1'b0);
    add_cfg(REG_RECORD_COUNT, 64'd2, 1'b0);
    add_byte(8'h00, ONE_RESULT, 0, -128, 1'b1, 1'b0);
    add_byte(8'hFF, ONE_RESULT, 0, 127, 1'b1, 1'b1);
    add_byte(8'h5A, NO_RESULT);
    add_cfg(REG_FIELD_COUNT, 64'd0, 1'b0);
    add_cfg(REG_FIELD_WIDTHS, 64'd31, 1'b0);
    add_cfg(REG_FIELD_BIASES, 64'h7F, 1'b0);
    add_cfg(REG_RECORD_COUNT, 64'd1, 1'b1);
    add_byte(8'hFF, NO_RESULT);
    add_byte(8'hFF, NO_RESULT);
    add_byte(8'hFF, NO_RESULT);
    add_byte(8'hFF, ONE_RESULT, 0, 64'd2147483774, 1'b1, 1'b1);
    add_cfg(REG_FIELD_COUNT, 64'd15, 1'b0);
    add_cfg(REG_FIELD_WIDTHS, 64'h08_4210_8421, 1'b0);
    add_cfg(REG_FIELD_BIASES, 64'h807F_01FF_0080_7FFE, 1'b0);
    add_cfg(REG_RECORD_COUNT, 64'd10, 1'b1);
    add_byte(8'hC3, BY_MODEL);
    add_byte(8'h3C, BY_MODEL);
    add_cfg(REG_FIELD_COUNT, 64'd4, 1'b0);
    add_cfg(REG_FIELD_WIDTHS, 64'h2_8040, 1'b0);
    add_cfg(REG_RECORD_COUNT, 64'd10, 1'b1);
    add_byte(8'h96, BY_MODEL);
    add_byte(8'h69, BY_MODEL);
    add_cfg(REG_FIELD_COUNT, 64'd2, 1'b0);
    add_cfg(REG_FIELD_WIDTHS, 64'hC6, 1'b0);
    add_byte(8'hE7, BY_MODEL);
    add_byte(8'h18, BY_MODEL);
    add_cfg(REG_FIELD_COUNT, 64'd1, 1'b0);
    add_cfg(REG_FIELD_WIDTHS, 64'd1, 1'b0);
    add_cfg(REG_RECORD_COUNT, 64'd1, 1'b1);
    add_byte(8'h55, BY_MODEL);
    add_byte(8'hAA, BY_MODEL);
    add_cfg(REG_RECORD_COUNT, 64'd1, 1'b1);
    add_byte(8'h0F, BY_MODEL);
    add_cfg(REG_RECORD_COUNT, 64'd1, 1'b1);
    add_byte(8'hF0, BY_MODEL);
    add_cfg(REG_RECORD_COUNT, 64'd1, 1'b1);
    add_byte(8'h81, BY_MODEL);
    add_cfg(REG_RECORD_COUNT, 64'd1, 1'b1);
    add_byte(8'h7E, BY_MODEL);
    add_cfg(REG_RECORD_COUNT, 64'd1, 1'b0);
    add_byte(8'h33, NO_RESULT);
    add_cfg(REG_FIELD_COUNT, 64'd3, 1'b0);
    add_cfg(REG_FIELD_WIDTHS, 64'h24E5, 1'b0);
    add_cfg(REG_FIELD_BIASES, 64'h0102_0304_05FF_FE80, 1'b0);
    add_cfg(REG_RECORD_COUNT, 64'd4, 1'b1);
    add_byte(8'h9C, BY_MODEL);
    add_byte(8'h47, BY_MODEL);
    add_byte(8'hE1, BY_MODEL);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        v = plan[i].from_done ? CFG_DATA_W'(recs_done) + plan[i].value : plan[i].value;
        write_reg(plan[i].reg_idx, v);
      end else begin
        cfg_valid <= 1'b0;
        send_byte(plan[i].data, plan[i].check == BY_MODEL, n);
        if (plan[i].check == ONE_RESULT) pending_fields = {pending_fields, plan[i].want};
      end
    end

    while (live_bytes < 480) begin
      settle();
      calm = (live_bytes >= 150 && live_bytes < 260);
      if (first_phase || $urandom_range(0, 99) < 70) begin
        roll = $urandom_range(0, 99);
        write_reg(REG_FIELD_COUNT, (roll < 10) ? CFG_DATA_W'($urandom_range(0, 15))
                                              : CFG_DATA_W'($urandom_range(1, MAX_FIELDS)));
      end
      if (first_phase || $urandom_range(0, 99) < 70)
        write_reg(REG_FIELD_WIDTHS, CFG_DATA_W'(pick_widths()));
      if ($urandom_range(0, 9) == 0)
        write_reg(REG_RECORD_COUNT + CFG_INDEX_W'($urandom_range(1, 4)), {$urandom, $urandom});
      if (first_phase || $urandom_range(0, 99) < 70)
        write_reg(REG_FIELD_BIASES, {$urandom, $urandom});
      write_reg(REG_RECORD_COUNT, CFG_DATA_W'(pick_records()));
      cfg_valid <= 1'b0;
      first_phase = 1'b0;
      nb = $urandom_range(4, 40);
      repeat (nb) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) b = 8'h00;
        else if (roll < 20) b = 8'hFF;
        else b = BYTE_BITS'($urandom_range(0, 255));
        send_byte(b, 1'b1, n);
        if (n >= 0) live_bytes++;
      end
    end
    calm = 1'b0;
    settle();

    if (mismatches == 0) begin
      $display("packed_record_field_unpacker regression: pass");
    end else begin
      $display("packed_record_field_unpacker regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("packed_record_field_unpacker regression: fail");
    $finish;
  end

endmodule
